// ===== rtl/dhfk_pkg.sv =====
// Shared types, constants and arithmetic helpers of the forward kinematics block.
// No dependencies.
`default_nettype none
package dhfk_pkg;

  localparam int AngW = 34;    // angle in units of 2^-28 rad, reduced range
  localparam int TrigW = 32;   // Q.28 sine and cosine, with headroom
  localparam int AccW = 48;    // position and rotation accumulators
  localparam int AtanEntries = 24;
  localparam int OutW = 18;

  localparam logic signed [AngW-1:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [AngW-1:0] PiQ28 = 34'sd843314857;
  localparam logic signed [AngW-1:0] TwoPiQ28 = 34'sd1686629713;
  localparam logic signed [TrigW-1:0] CordicGain = 32'sd163008219;
  localparam logic signed [AccW-1:0] OneQ28 = 48'sd268435456;

  localparam logic [2:0] RegBaseHeight = 3'd0;
  localparam logic [2:0] RegShoulder = 3'd1;
  localparam logic [2:0] RegElbow = 3'd2;
  localparam logic [2:0] RegWrist = 3'd3;
  localparam logic [2:0] RegUpperArm = 3'd4;
  localparam logic [2:0] RegForearm = 3'd5;
  localparam logic [2:0] RegTool = 3'd6;
  localparam logic [2:0] RegInvert = 3'd7;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } sincos_t;

  typedef struct packed {
    logic signed [15:0] base_height;
    logic signed [15:0] shoulder_offset;
    logic signed [15:0] elbow_offset;
    logic signed [15:0] wrist_offset;
    logic signed [15:0] upper_arm_length;
    logic signed [15:0] forearm_length;
    logic signed [15:0] tool_length;
  } geom_t;

  function automatic logic signed [AngW-1:0] atan_q28(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0: r = 34'sd210828714;
      5'd1: r = 34'sd124459457;
      5'd2: r = 34'sd65760959;
      5'd3: r = 34'sd33381290;
      5'd4: r = 34'sd16755422;
      5'd5: r = 34'sd8385879;
      5'd6: r = 34'sd4193963;
      5'd7: r = 34'sd2097109;
      5'd8: r = 34'sd1048571;
      5'd9: r = 34'sd524287;
      default: r = (i < 5'd24) ? (34'sd1 <<< (5'd28 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  // Product of two signed values rounded to Q.28: (a*b + 2^27) >>> 28.
  // The first operand is always a rotation entry or a scaled length, both of which
  // fit in TrigW bits, so the multiplier is TrigW by TrigW.
  function automatic logic signed [AccW-1:0] mulq(input logic signed [AccW-1:0] a,
                                                  input logic signed [TrigW-1:0] b);
    logic signed [2*TrigW-1:0] p;
    p = TrigW'(a) * b + (64'sd1 <<< 27);
    return AccW'(p >>> 28);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dhfk_cordic.sv =====
// One lane: range reduction and pipelined CORDIC giving sine and cosine of an angle.
// Depends on dhfk_pkg.
`default_nettype none
module dhfk_cordic
  import dhfk_pkg::*;
#(
  parameter int Steps = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [AngW-1:0]  angle_i,
  output sincos_t                      res_o
);

  logic signed [AngW-1:0] red;
  logic                   flip_in;

  // Input magnitude is at most 8 rad plus pi/2, so two wraps suffice.
  always_comb begin
    red = angle_i;
    if (red > PiQ28) red = red - TwoPiQ28;
    if (red > PiQ28) red = red - TwoPiQ28;
    if (red < -PiQ28) red = red + TwoPiQ28;
    if (red < -PiQ28) red = red + TwoPiQ28;
    flip_in = 1'b0;
    if (red > HalfPiQ28) begin
      red = red - PiQ28;
      flip_in = 1'b1;
    end else if (red < -HalfPiQ28) begin
      red = red + PiQ28;
      flip_in = 1'b1;
    end
  end

  logic signed [TrigW-1:0] x_q [Steps+1];
  logic signed [TrigW-1:0] y_q [Steps+1];
  logic signed [AngW-1:0]  z_q [Steps+1];
  logic                    f_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= red;
      f_q[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q28(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q28(5'(i));
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  assign res_o.c = f_q[Steps] ? -x_q[Steps] : x_q[Steps];
  assign res_o.s = f_q[Steps] ? -y_q[Steps] : y_q[Steps];

endmodule
`default_nettype wire

// ===== rtl/dhfk_chain.sv =====
// Merging stage: chains the four link transforms and the tool offset; link 1 fills stage
// 0, then one link per stage pair (products registered, then sums). Depends on dhfk_pkg.
`default_nettype none
module dhfk_chain
  import dhfk_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire sincos_t                sc_i [4],
  input  wire geom_t                  geom_i,
  output logic signed [OutW-1:0]      pos_x_o,
  output logic signed [OutW-1:0]      pos_y_o,
  output logic signed [OutW-1:0]      pos_z_o,
  output logic                        saturated_o
);

  typedef logic signed [AccW-1:0] acc_t;
  localparam int NStage = 7;

  // Stage 0: link 1 (alpha -pi/2, a=0). R = [[c,0,-s],[s,0,c],[0,-1,0]], P = (0,0,d1).
  // Stage pairs then apply links 2, 3 (alpha 0) and 4 (alpha pi/2); the tool offset follows at the output.
  acc_t r_q [NStage][3][3];
  acc_t p_q [NStage][3];
  sincos_t sc_q [NStage][4];

  function automatic acc_t ext(input logic signed [TrigW-1:0] v);
    return AccW'(v);
  endfunction

  function automatic acc_t len(input logic signed [15:0] v);
    return AccW'(v) <<< 8;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0][0][0] <= ext(sc_i[0].c); r_q[0][0][1] <= '0; r_q[0][0][2] <= -ext(sc_i[0].s);
      r_q[0][1][0] <= ext(sc_i[0].s); r_q[0][1][1] <= '0; r_q[0][1][2] <= ext(sc_i[0].c);
      r_q[0][2][0] <= '0; r_q[0][2][1] <= -OneQ28; r_q[0][2][2] <= '0;
      p_q[0][0] <= '0; p_q[0][1] <= '0; p_q[0][2] <= len(geom_i.base_height);
      sc_q[0] <= sc_i;
    end
  end

  acc_t pa_q [3][2];       // a*cos, a*sin for each link

  for (genvar l = 0; l < 3; l++) begin : g_link
    localparam int S = 2 * l;  // source stage for pa products
    logic signed [15:0] a_len, d_len;
    logic alpha_zero;
    assign a_len = (l == 0) ? geom_i.upper_arm_length :
                   (l == 1) ? geom_i.forearm_length : 16'sd0;
    assign d_len = (l == 0) ? geom_i.shoulder_offset :
                   (l == 1) ? geom_i.elbow_offset : geom_i.wrist_offset;
    assign alpha_zero = (l != 2);

    acc_t r1 [3][3];
    acc_t p1 [3];
    sincos_t sc1;
    acc_t pz_q;

    // Stage S -> S+1: a*cos, a*sin.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[l][0] <= mulq(len(a_len), sc_q[S][l+1].c);
        pa_q[l][1] <= mulq(len(a_len), sc_q[S][l+1].s);
        pz_q <= len(d_len);
        r_q[S+1] <= r_q[S];
        p_q[S+1] <= p_q[S];
        sc_q[S+1] <= sc_q[S];
      end
    end
    assign r1 = r_q[S+1];
    assign p1 = p_q[S+1];
    assign sc1 = sc_q[S+1][l+1];

    // Stage S+1 -> S+2: rotation and translation products, then summed.
    acc_t nr [3][3];
    acc_t np [3];
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        np[r] = p1[r] + mulq(r1[r][0], TrigW'(pa_q[l][0]))
                      + mulq(r1[r][1], TrigW'(pa_q[l][1]))
                      + mulq(r1[r][2], TrigW'(pz_q));
        if (alpha_zero) begin
          nr[r][0] = mulq(r1[r][0], sc1.c) + mulq(r1[r][1], sc1.s);
          nr[r][1] = mulq(r1[r][0], -sc1.s) + mulq(r1[r][1], sc1.c);
          nr[r][2] = r1[r][2];
        end else begin
          // The cosine is negated before rounding, as the matrix entry is -cos.
          nr[r][0] = mulq(r1[r][0], sc1.c) + mulq(r1[r][1], sc1.s);
          nr[r][1] = r1[r][2];
          nr[r][2] = mulq(r1[r][0], sc1.s) + mulq(r1[r][1], -sc1.c);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[S+2] <= nr;
        p_q[S+2] <= np;
        sc_q[S+2] <= sc_q[S+1];
      end
    end
  end

  // Tool offset along the final z axis, then rounding and clipping.
  acc_t fin [3];
  logic signed [OutW-1:0] o_d [3];
  logic s_d [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      fin[r] = (p_q[6][r] + mulq(r_q[6][r][2], TrigW'(len(geom_i.tool_length)))
                + 48'sd128) >>> 8;
      s_d[r] = 1'b0;
      o_d[r] = OutW'(fin[r]);
      if (fin[r] > 48'sd131071) begin
        o_d[r] = 18'sd131071; s_d[r] = 1'b1;
      end else if (fin[r] < -48'sd131072) begin
        o_d[r] = -18'sd131072; s_d[r] = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_o <= o_d[0];
      pos_y_o <= o_d[1];
      pos_z_o <= o_d[2];
      saturated_o <= s_d[0] | s_d[1] | s_d[2];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dh_forward_kinematics_position.sv =====
// Four-joint arm end-effector position by Denavit-Hartenberg forward kinematics.
//
// Input channel: in_valid_i / in_stall_o with four Q3.12 joint angles per beat.
// Output channel: out_valid_o / out_stall_i with pos_x, pos_y, pos_z and saturated.
// A beat is taken at a rising edge with valid high and stall low.
// Four CORDIC lanes (one per joint) run side by side, CORDIC_STEPS+1 stages deep,
// and the link chain adds eight stages behind them.
// The whole pipeline advances as one shift line: one pose per cycle is accepted
// while no result waits on a stalled receiver. When the receiver stalls with a
// result waiting, the whole pipeline freezes, the result stays put, and in_stall_o
// is high for as long as that lasts.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect immediately;
// write only while idle. Reset clears the valid line and loads the register defaults.
// Depends on dhfk_pkg, dhfk_cordic and dhfk_chain.
`default_nettype none
module dh_forward_kinematics_position
  import dhfk_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] joint1_angle_i,
  input  wire logic signed [15:0] joint2_angle_i,
  input  wire logic signed [15:0] joint3_angle_i,
  input  wire logic signed [15:0] joint4_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [17:0]      pos_x_o,
  output logic signed [17:0]      pos_y_o,
  output logic signed [17:0]      pos_z_o,
  output logic                    saturated_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int Depth = CORDIC_STEPS + 9;

  geom_t      geom_q;
  logic [3:0] invert_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.base_height <= 16'sd1376;
      geom_q.shoulder_offset <= 16'sd1819;
      geom_q.elbow_offset <= -16'sd1483;
      geom_q.wrist_offset <= 16'sd1121;
      geom_q.upper_arm_length <= -16'sd7373;
      geom_q.forearm_length <= -16'sd6390;
      geom_q.tool_length <= 16'sd3960;
      invert_mask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBaseHeight: geom_q.base_height <= cfg_data_i;
        RegShoulder:   geom_q.shoulder_offset <= cfg_data_i;
        RegElbow:      geom_q.elbow_offset <= cfg_data_i;
        RegWrist:      geom_q.wrist_offset <= cfg_data_i;
        RegUpperArm:   geom_q.upper_arm_length <= cfg_data_i;
        RegForearm:    geom_q.forearm_length <= cfg_data_i;
        RegTool:       geom_q.tool_length <= cfg_data_i;
        RegInvert:     invert_mask_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Valid line; bit k holds the valid flag of the item in data stage k, shifting with it.
  logic [Depth-1:0] vld_q, vld_d;
  logic             en;
  logic             in_acc;

  assign out_valid_o = vld_q[Depth-1];
  // Advance unless the output holds a stalled result.
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc = in_valid_i && en;

  always_comb begin
    vld_d = vld_q;
    if (en) vld_d = {vld_q[Depth-2:0], in_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= vld_d;
  end

  logic signed [15:0] ang [4];
  assign ang[0] = joint1_angle_i;
  assign ang[1] = joint2_angle_i;
  assign ang[2] = joint3_angle_i;
  assign ang[3] = joint4_angle_i;

  sincos_t sc [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic signed [AngW-1:0] a;
    logic signed [AngW-1:0] q;
    assign q = invert_mask_q[j] ? -(AngW'(ang[j])) : AngW'(ang[j]);
    assign a = (q <<< 16) + ((j == 1 || j == 2) ? HalfPiQ28 : '0);
    dhfk_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
      .clk_i  (clk_i),
      .en_i   (en),
      .angle_i(a),
      .res_o  (sc[j])
    );
  end

  dhfk_chain u_chain (
    .clk_i      (clk_i),
    .en_i       (en),
    .sc_i       (sc),
    .geom_i     (geom_q),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .saturated_o(saturated_o)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted beat not entered");
`endif

endmodule
`default_nettype wire

// ===== test/dh_forward_kinematics_position_test.sv =====
// Self-checking testbench of dh_forward_kinematics_position: directed and random poses,
// with a scoreboard class that predicts each position in 64-bit integer arithmetic.
// Depends on dhfk_pkg and the block's RTL.
`default_nettype none
module dh_forward_kinematics_position_test
  import dhfk_pkg::*;
();

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic sat;
  } pose_pos_t;

  class pose_scoreboard;
    pose_pos_t pending_q[$];
    int mismatches;
    logic signed [15:0] geom[7];
    logic [3:0] invert;

    function new();
      mismatches = 0;
      geom = '{16'sd1376, 16'sd1819, -16'sd1483, 16'sd1121, -16'sd7373, -16'sd6390,
               16'sd3960};
      invert = 4'd0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      if (idx == RegInvert) invert = data[3:0];
      else geom[idx] = data;
    endfunction

    function longint atan_entry(int i);
      longint t[16] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                        32768, 16384, 8192};
      return t[i];
    endfunction

    function longint rmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function void rotate(longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      x = 163008219;
      y = 0;
      flip = 0;
      while (ang > 843314857) ang -= 1686629713;
      while (ang < -843314857) ang += 1686629713;
      if (ang > 421657428) begin
        ang -= 843314857;
        flip = 1;
      end else if (ang < -421657428) begin
        ang += 843314857;
        flip = 1;
      end
      z = ang;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_entry(i);
        end else begin
          x += dx; y -= dy; z += atan_entry(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Chains the four link transforms and the tool offset for one accepted pose.
    function void note_pose(logic signed [15:0] q1, logic signed [15:0] q2,
                            logic signed [15:0] q3, logic signed [15:0] q4);
      longint r[3][3], nr[3][3], p[3], np[3], am[3][3], pa[3];
      longint q[4], d[4], a[4], ca, sa, ct, st, tl, v;
      longint acos_t[4] = '{0, 1, 1, 0};
      longint asin_t[4] = '{-1, 0, 0, 1};
      longint off[4] = '{0, 421657428, 421657428, 0};
      pose_pos_t e;
      longint res[3];
      r = '{'{268435456, 0, 0}, '{0, 268435456, 0}, '{0, 0, 268435456}};
      p = '{0, 0, 0};
      q = '{q1, q2, q3, q4};
      for (int j = 0; j < 4; j++) d[j] = longint'(geom[j]) * 256;
      a = '{0, longint'(geom[4]) * 256, longint'(geom[5]) * 256, 0};
      e.sat = 0;
      for (int j = 0; j < 4; j++) begin
        if (invert[j]) q[j] = -q[j];
        rotate(q[j] * 65536 + off[j], ct, st);
        ca = acos_t[j];
        sa = asin_t[j];
        am = '{'{ct, -st * ca, st * sa}, '{st, ct * ca, -ct * sa},
               '{0, sa * 268435456, ca * 268435456}};
        pa = '{rmul(a[j], ct), rmul(a[j], st), d[j]};
        for (int i = 0; i < 3; i++) begin
          np[i] = p[i];
          for (int k = 0; k < 3; k++) np[i] += rmul(r[i][k], pa[k]);
          for (int c = 0; c < 3; c++) begin
            nr[i][c] = 0;
            for (int k = 0; k < 3; k++) nr[i][c] += rmul(r[i][k], am[k][c]);
          end
        end
        r = nr;
        p = np;
      end
      tl = longint'(geom[6]) * 256;
      for (int i = 0; i < 3; i++) begin
        v = (p[i] + rmul(r[i][2], tl) + 128) >>> 8;
        if (v > 131071) begin
          v = 131071; e.sat = 1;
        end else if (v < -131072) begin
          v = -131072; e.sat = 1;
        end
        res[i] = v;
      end
      e.x = 18'(res[0]);
      e.y = 18'(res[1]);
      e.z = 18'(res[2]);
      pending_q = {pending_q, e};
    endfunction

    function void check_pos(pose_pos_t got);
      pose_pos_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected position beat x=%0d y=%0d z=%0d",
                                       got.x, got.y, got.z);
        return;
      end
      e = pending_q.pop_front();
      if (e.x !== got.x || e.y !== got.y || e.z !== got.z || e.sat !== got.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("position mismatch: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                   e.x, e.y, e.z, e.sat, got.x, got.y, got.z, got.sat);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [15:0] joint1_angle_i = 0, joint2_angle_i = 0;
  logic signed [15:0] joint3_angle_i = 0, joint4_angle_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [17:0] pos_x_o, pos_y_o, pos_z_o;
  logic saturated_o;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = 0;
  logic [15:0] cfg_data_i = 0;

  dh_forward_kinematics_position DUT (.*);

  pose_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("dh_forward_kinematics_position_test NOT OK");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pose_pos_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x = pos_x_o;
      got.y = pos_y_o;
      got.z = pos_z_o;
      got.sat = saturated_o;
      sb.check_pos(got);
    end
  end

  task automatic send_pose(logic signed [15:0] a1, logic signed [15:0] a2,
                           logic signed [15:0] a3, logic signed [15:0] a4);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    joint1_angle_i = a1;
    joint2_angle_i = a2;
    joint3_angle_i = a3;
    joint4_angle_i = a4;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pose(a1, a2, a3, a4);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(logic [15:0] g, logic [3:0] inv);
    for (int i = 0; i < 7; i++) write_reg(3'(i), g);
    write_reg(RegInvert, {12'hFFF, inv});
  endtask

  task automatic random_geometry();
    logic [15:0] v;
    for (int i = 0; i < 7; i++) begin
      case ($urandom_range(0, 4))
        0: v = 16'h7FFF;
        1: v = 16'h8000;
        default: v = 16'($urandom_range(0, 65535));
      endcase
      write_reg(3'(i), v);
    end
    write_reg(RegInvert, 16'($urandom_range(0, 65535)));
  endtask

  task automatic random_pose();
    logic signed [15:0] a[4];
    for (int i = 0; i < 4; i++)
      case ($urandom_range(0, 9))
        0: a[i] = -16'sd32768;
        1: a[i] = 16'sd32767;
        2: a[i] = 16'($urandom_range(0, 12868) - 6434);  // within about +-pi/2
        default: a[i] = 16'($urandom_range(0, 65535));
      endcase
    send_pose(a[0], a[1], a[2], a[3]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry: zero pose, extremes and right angles.
    send_pose(0, 0, 0, 0);
    send_pose(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_pose(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pose(16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868);
    send_pose(16'sd32767, -16'sd32768, 0, 16'sd6434);
    send_pose(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    drain();
    // Longest links with every joint inverted: full-magnitude negation and clipping.
    write_all(16'h7FFF, 4'hF);
    send_pose(0, 0, 0, 0);
    send_pose(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pose(16'sd32767, 0, -16'sd32768, 0);
    send_pose(16'sd6434, 16'sd6434, -16'sd6434, 16'sd6434);
    send_pose(0, -16'sd6434, 0, 0);
    drain();
    write_all(16'h8000, 4'hA);
    send_pose(0, 0, 0, 0);
    send_pose(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_pose(16'sd12868, -16'sd12868, 16'sd6434, -16'sd6434);
    send_pose(0, -16'sd6434, -16'sd6434, 0);
    drain();
    write_all(16'h0000, 4'h5);
    send_pose(16'sd100, -16'sd32768, 16'sd32767, -16'sd32768);
    drain();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 28 : (m == 1) ? 53 : 0;
      recv_idle_pct = (m == 0) ? 53 : (m == 1) ? 28 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        random_geometry();
        for (int n = 0; n < 105; n++) random_pose();
        drain();
      end
    end

    // Long receiver hold-off while poses keep coming, so the pipe fills and stalls.
    hold_cycles = 300;
    for (int n = 0; n < 60; n++) random_pose();
    drain();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("dh_forward_kinematics_position_test OK");
    else
      $display("dh_forward_kinematics_position_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ===== dh_forward_kinematics_position.f =====
rtl/dhfk_pkg.sv
rtl/dhfk_cordic.sv
rtl/dhfk_chain.sv
rtl/dh_forward_kinematics_position.sv
test/dh_forward_kinematics_position_test.sv
